/* rtl/stable_priority_queue_ring_assert.svh */
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_RING_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_RING_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SPQR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define SPQR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spqr_pkg.sv */
// Types and constants of the ring priority queue.
package spqr_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned PRI_W       = 8;
  localparam int unsigned ENTRY_W     = DATA_W + PRI_W;
  localparam int unsigned IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FIRST  = 4'b0010,
    S_BUBBLE = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  // Priority sits above the value, matching the stream data layout.
  typedef struct packed {
    logic [PRI_W-1:0]  pri;
    logic [DATA_W-1:0] value;
  } entry_t;

endpackage

/* rtl/stable_priority_queue_ring.sv */
// Enqueue, full and empty reports go straight to S_RESULT to wait for the output register.
// A dequeue runs S_FIRST and, holding more than one entry, a bubble pass from tail
// to head, one ring slot per cycle through the RAM read port, before S_RESULT.
// The next beat is accepted once the result has been loaded into the output register.
// Reset empties the queue (count, head and tail to zero); the entry RAM is not cleared,
// since the data of slots that hold no entry is never used.
`include "stable_priority_queue_ring_assert.svh"

module stable_priority_queue_ring
  import spqr_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: item_value [31:0], item_priority [39:32]
  input  logic [IN_TDATA_W-1:0]                  s_axis_tdata_i,
  // tuser: operation [0]
  input  logic [0:0]                             s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // tdata: out_value [31:0], out_priority [39:32], occupancy above, zero padded
  output logic [((ENTRY_W + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // tuser: status [1:0]
  output logic [STATUS_W-1:0]                    m_axis_tuser_o
);

  localparam int unsigned IW          = $clog2(DEPTH);
  localparam int unsigned CW          = $clog2(DEPTH + 1);
  localparam int unsigned OUT_TDATA_W = ((ENTRY_W + CW + 7) / 8) * 8;
  localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // Ring neighbors; DEPTH need not be a power of two.
  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx);
    ring_prev = (idx == '0) ? LAST_IDX : idx - 1'b1;
  endfunction

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
    ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  // Control state.
  state_e          state_q, state_d;
  logic [IW-1:0]   head_q, head_d;
  logic [IW-1:0]   tail_q, tail_d;
  logic [CW-1:0]   count_q, count_d;
  logic            out_valid_q, out_valid_d;

  // Bubble pass registers: slot being written, slot whose data is arriving,
  // and the entry carried toward the head.
  logic [IW-1:0]   wr_idx_q, wr_idx_d;
  logic [IW-1:0]   rd_idx_q, rd_idx_d;
  entry_t          carried_q, carried_d;

  // Finished result waiting for the output register, and the output register.
  status_e         res_status_q, res_status_d;
  entry_t          res_entry_q, res_entry_d;
  logic [CW-1:0]   res_occ_q, res_occ_d;
  status_e         out_status_q, out_status_d;
  entry_t          out_entry_q, out_entry_d;
  logic [CW-1:0]   out_occ_q, out_occ_d;

  // RAM port.
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [IW-1:0]   ram_raddr;
  entry_t          rd_entry;

  logic            in_accept;
  op_e             in_op;
  entry_t          in_entry;
  logic [IW-1:0]   new_tail;
  logic            carried_wins;
  entry_t          keep_entry;
  logic            finish;
  entry_t          win_entry;
  logic            out_load;

  spqr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op           = op_e'(s_axis_tuser_i[0]);
  assign in_entry        = entry_t'(s_axis_tdata_i[ENTRY_W-1:0]);

  // An enqueue into an empty queue restarts the ring at slot zero.
  assign new_tail = (count_q == '0) ? '0 : ring_next(tail_q);

  // Strict compare keeps the pass stable: on equal priority the entry nearer
  // the head, which was inserted earlier, goes on being carried.
  assign carried_wins = (carried_q.pri > rd_entry.pri);
  assign keep_entry   = carried_wins ? carried_q : rd_entry;

  assign out_load = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    carried_d    = carried_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    res_occ_d    = res_occ_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_idx_q;
    ram_wdata    = carried_q;
    ram_raddr    = tail_q;
    finish       = 1'b0;
    win_entry    = rd_entry;

    unique case (state_q)
      S_IDLE: begin
        // The tail slot is read on every idle cycle so a dequeue finds it ready.
        ram_raddr = tail_q;
        if (in_accept) begin
          if (in_op == OP_ENQUEUE) begin
            if (count_q == FULL_CNT) begin
              res_status_d = ST_FULL;
              res_entry_d  = '0;
              res_occ_d    = count_q;
            end else begin
              ram_we       = 1'b1;
              ram_waddr    = new_tail;
              ram_wdata    = in_entry;
              tail_d       = new_tail;
              if (count_q == '0) begin
                head_d = '0;
              end
              count_d      = count_q + 1'b1;
              res_status_d = ST_INSERTED;
              res_entry_d  = '0;
              res_occ_d    = count_q + 1'b1;
            end
            state_d = S_RESULT;
          end else if (count_q == '0) begin
            res_status_d = ST_EMPTY;
            res_entry_d  = '0;
            res_occ_d    = '0;
            state_d      = S_RESULT;
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        // Tail entry arrives; it becomes the carried entry.
        ram_raddr = ring_prev(tail_q);
        if (tail_q == head_q) begin
          finish    = 1'b1;
          win_entry = rd_entry;
        end else begin
          carried_d = rd_entry;
          wr_idx_d  = tail_q;
          rd_idx_d  = ring_prev(tail_q);
          state_d   = S_BUBBLE;
        end
      end
      S_BUBBLE: begin
        // The loser of each compare is left behind in the slot just vacated.
        ram_raddr = ring_prev(rd_idx_q);
        ram_we    = 1'b1;
        ram_waddr = wr_idx_q;
        ram_wdata = carried_wins ? rd_entry : carried_q;
        if (rd_idx_q == head_q) begin
          finish    = 1'b1;
          win_entry = keep_entry;
        end else begin
          carried_d = keep_entry;
          wr_idx_d  = rd_idx_q;
          rd_idx_d  = ring_prev(rd_idx_q);
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The winner is taken as the result, and the head slot is released.
    if (finish) begin
      res_status_d = ST_REMOVED;
      res_entry_d  = win_entry;
      res_occ_d    = count_q - 1'b1;
      count_d      = count_q - 1'b1;
      if (count_q == CW'(1)) begin
        head_d = '0;
        tail_d = '0;
      end else begin
        head_d = ring_next(head_q);
      end
      state_d = S_RESULT;
    end
  end

  // Output register: holds a result until the downstream side takes it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_occ_d    = out_occ_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_entry_d  = res_entry_q;
      out_occ_d    = res_occ_q;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q     <= wr_idx_d;
    rd_idx_q     <= rd_idx_d;
    carried_q    <= carried_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    res_occ_q    <= res_occ_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_occ_q    <= out_occ_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_occ_q, out_entry_q});

  `SPQR_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= FULL_CNT, "entry count above depth")
  `SPQR_ASSERT_SAME(a_empty_ring_home, clk_i, rst_ni, count_q == '0, head_q == '0 && tail_q == '0, "empty queue with ring pointers away from slot zero")
  `SPQR_ASSERT_NEXT(a_enqueue_count, clk_i, rst_ni, in_accept && in_op == OP_ENQUEUE && count_q != FULL_CNT, count_q == CW'($past(count_q) + 1'b1), "enqueue did not raise the count by one")
  `SPQR_ASSERT_SAME(a_bubble_slots_differ, clk_i, rst_ni, state_q == S_BUBBLE, wr_idx_q != rd_idx_q && wr_idx_q != head_q, "bubble pass write and read slots collide")

endmodule

/* rtl/spqr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module spqr_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the ring priority queue: stream stimulus, ordering predictor.
module testbench;
  import spqr_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = 16;
  localparam int unsigned SLOT_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OUT_TDATA_W   = ((ENTRY_W + OCC_W + 7) / 8) * 8;
  localparam int unsigned CLK_PERIOD    = 20;
  // This leaves a wide margin after the last reply, longer than a full dequeue takes.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned MAX_REPORTS   = 10;

  // One predicted reply beat, with the fields in the order they leave the block.
  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] value;
    logic [PRI_W-1:0]  pri;
    logic [OCC_W-1:0]  occupancy;
  } reply_t;

  logic                   clk_i;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid   = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata    = '0;
  logic [0:0]             s_axis_tuser    = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready   = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  stable_priority_queue_ring #(
    .DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // The predictor's own copy of the queue: a ring of slots with head, tail and count.
  logic [DATA_W-1:0] slot_value [QUEUE_DEPTH];
  logic [PRI_W-1:0]  slot_pri   [QUEUE_DEPTH];
  logic [SLOT_W-1:0] head_slot  = '0;
  logic [SLOT_W-1:0] tail_slot  = '0;
  int unsigned       held_count = 0;

  reply_t pending_replies [$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned inserts_seen   = 0;
  int unsigned full_rejects   = 0;
  int unsigned removals_seen  = 0;
  int unsigned empty_reads    = 0;

  // Sender pacing: bursts of random length separated by random gaps, when enabled.
  bit          gaps_enabled = 1'b1;
  int unsigned burst_left   = 0;

  // Each increment asks the receiver process for one long hold-off.
  int unsigned hold_requests = 0;

  // Computes the reply to one beat and updates the queue image. A dequeue runs one
  // bubble pass from the tail back to the head: an entry moves toward the head only on
  // a strictly greater priority, so equal priorities keep their insertion order.
  function automatic reply_t predict_queue_reply(op_e op, logic [DATA_W-1:0] value,
                                                 logic [PRI_W-1:0] pri);
    reply_t            r;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] nbr;
    logic [DATA_W-1:0] swap_value;
    logic [PRI_W-1:0]  swap_pri;
    r.value = '0;
    r.pri   = '0;
    if (op == OP_ENQUEUE) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // An empty queue restarts at slot zero.
        if (held_count == 0) begin
          head_slot = '0;
          tail_slot = '0;
        end else begin
          tail_slot = SLOT_W'((tail_slot + 1) % QUEUE_DEPTH);
        end
        slot_value[tail_slot] = value;
        slot_pri[tail_slot]   = pri;
        held_count++;
        r.status = ST_INSERTED;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      idx = tail_slot;
      while (idx != head_slot) begin
        nbr = SLOT_W'((idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
        if (slot_pri[idx] > slot_pri[nbr]) begin
          swap_value      = slot_value[idx];
          swap_pri        = slot_pri[idx];
          slot_value[idx] = slot_value[nbr];
          slot_pri[idx]   = slot_pri[nbr];
          slot_value[nbr] = swap_value;
          slot_pri[nbr]   = swap_pri;
        end
        idx = nbr;
      end
      r.value = slot_value[head_slot];
      r.pri   = slot_pri[head_slot];
      held_count--;
      // Removing the last entry sends both pointers back to slot zero.
      if (held_count == 0) begin
        head_slot = '0;
        tail_slot = '0;
      end else begin
        head_slot = SLOT_W'((head_slot + 1) % QUEUE_DEPTH);
      end
      r.status = ST_REMOVED;
    end
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  // Offers one beat and returns at the edge that accepts it. Any gap is taken before the
  // beat, so tvalid is never lowered and raised in one time step.
  task automatic send_item(op_e op, logic [DATA_W-1:0] value, logic [PRI_W-1:0] pri);
    int unsigned gap;
    reply_t      r;
    if (gaps_enabled && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pri, value};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_queue_reply(op, value, pri);
    pending_replies.push_back(r);
    items_sent++;
    case (r.status)
      ST_INSERTED: inserts_seen++;
      ST_FULL:     full_rejects++;
      ST_REMOVED:  removals_seen++;
      ST_EMPTY:    empty_reads++;
    endcase
  endtask

  // Random beat: enq_percent sets the share of enqueues. Priorities are drawn often from a
  // tiny set so that ties are common, and values and priorities hit their extremes.
  task automatic send_random_item(int unsigned enq_percent);
    op_e               op;
    logic [DATA_W-1:0] value;
    logic [PRI_W-1:0]  pri;
    op = ($urandom_range(1, 100) <= enq_percent) ? OP_ENQUEUE : OP_DEQUEUE;
    case ($urandom_range(0, 9))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7FFF_FFFF;
      2:       value = 32'hFFFF_FFFF;
      default: value = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: pri = PRI_W'($urandom_range(0, 3));
      3:       pri = '0;
      4:       pri = '1;
      default: pri = PRI_W'($urandom);
    endcase
    send_item(op, value, pri);
  endtask

  // Lowers tvalid in the step of the last acceptance and waits for every reply, then a
  // little longer so that a stray extra beat would still be caught.
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Empty reads, a lone entry in and out, and the empty read after it.
  task automatic test_empty_queue();
    send_item(OP_DEQUEUE, 32'h1234_5678, 8'hA5);
    send_item(OP_ENQUEUE, 32'h7FFF_FFFF, 8'hFF);
    send_item(OP_DEQUEUE, '0, '0);
    send_item(OP_DEQUEUE, 32'hFFFF_FFFF, 8'hFF);
  endtask

  // Fills all slots with tied and extreme priorities, then pushes once more into a full
  // queue. The drain that follows in the random part checks the serving order.
  task automatic test_fill_to_capacity();
    logic [DATA_W-1:0] value;
    logic [PRI_W-1:0]  pri;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      case (k)
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'h0000_0000;
        3:       value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      case (k)
        0, 1, 2, 3, 4, 5: pri = 8'd7;
        6:                pri = 8'h00;
        7, 8:             pri = 8'hFF;
        9:                pri = 8'd1;
        10:               pri = 8'h80;
        default:          pri = PRI_W'($urandom);
      endcase
      send_item(OP_ENQUEUE, value, pri);
    end
    send_item(OP_ENQUEUE, 32'hDEAD_BEEF, 8'h5A);
  endtask

  // The receiver holds off for a long stretch while beats keep coming back to back; the
  // block's result register fills and its input must stall until the hold ends.
  task automatic test_output_hold();
    gaps_enabled = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (48) send_random_item(40);
    gaps_enabled = 1'b1;
  endtask

  // Phases that lean toward filling, draining or balance, so the ring wraps and both the
  // full and the empty boundary are reached many times. Some phases run without gaps.
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned done;
    int unsigned phase_len;
    int unsigned enq_percent;
    done = 0;
    while (done < n_items) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       enq_percent = 80;
        1:       enq_percent = 20;
        default: enq_percent = 50;
      endcase
      gaps_enabled = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        if (done < n_items) begin
          send_random_item(enq_percent);
          done++;
        end
      end
    end
    gaps_enabled = 1'b1;
  endtask

  // Receiver: a ready pattern that changes mode at random intervals, and a long hold
  // whenever the stimulus asks for one.
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned ready_mode  = 0;
  int unsigned mode_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served   <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  task automatic note_mismatch(string field_name, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH at %0t: %s expected %h, got %h", $realtime, field_name, want, got);
  endtask

  // Reply checker: every accepted beat is compared with the oldest prediction.
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        note_mismatch("unexpected beat, tdata", '0, m_axis_tdata[DATA_W-1:0]);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser != want.status)
          note_mismatch("status", DATA_W'(want.status), DATA_W'(m_axis_tuser));
        if (m_axis_tdata[DATA_W-1:0] != want.value)
          note_mismatch("out_value", want.value, m_axis_tdata[DATA_W-1:0]);
        if (m_axis_tdata[ENTRY_W-1:DATA_W] != want.pri)
          note_mismatch("out_priority", DATA_W'(want.pri),
                        DATA_W'(m_axis_tdata[ENTRY_W-1:DATA_W]));
        if (m_axis_tdata[ENTRY_W+OCC_W-1:ENTRY_W] != want.occupancy)
          note_mismatch("occupancy", DATA_W'(want.occupancy),
                        DATA_W'(m_axis_tdata[ENTRY_W+OCC_W-1:ENTRY_W]));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_fill_to_capacity();
    test_output_hold();
    test_random_traffic(780);
    wait_until_drained();
    $display("Covered %0d beats: %0d inserts, %0d full rejects, %0d removals, %0d empty reads,",
             items_sent, inserts_seen, full_rejects, removals_seen, empty_reads);
    $display("under random bursts, receiver stalls and one %0d-cycle output hold.",
             HOLD_CYCLES);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d replies outstanding", mismatch_count,
               pending_replies.size());
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d replies outstanding", pending_replies.size());
    $display("status: fail");
    $finish;
  end

endmodule
